/* rtl/lcsp_pkg.sv */
// Package for the label-constrained shortest path block.
// Holds the opcode and controller state types and the fixed field widths.
// No dependencies.
package lcsp_pkg;

  localparam int unsigned OP_BITS      = 2;
  localparam int unsigned NODE_BITS    = 6;
  localparam int unsigned LEN_BITS     = 8;
  localparam int unsigned LABEL_BITS   = 5;
  localparam int unsigned PATH_BITS    = 19;
  localparam int unsigned LABEL_STATES = 27;

  // One past the last letter: the label of the start state.
  localparam logic [LABEL_BITS-1:0] START_LABEL = 5'd26;

  typedef enum logic [OP_BITS-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INIT,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_SETTLE,
    ST_EDGE_RD,
    ST_EDGE_CHK,
    ST_RELAX,
    ST_DONE
  } state_e;

endpackage

/* rtl/lcsp_in_if.sv */
// Input channel of the shortest path block: edge loads, clears and queries.
// Uses the field widths of lcsp_pkg.
interface lcsp_in_if
  import lcsp_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [OP_BITS-1:0]    op;
  logic [NODE_BITS-1:0]  node_a;
  logic [NODE_BITS-1:0]  node_b;
  logic [LEN_BITS-1:0]   word_length;
  logic [LABEL_BITS-1:0] label_letter;

  modport source (output valid, op, node_a, node_b, word_length, label_letter, input ready);
  modport sink   (input valid, op, node_a, node_b, word_length, label_letter, output ready);
endinterface

/* rtl/lcsp_out_if.sv */
// Result channel of the shortest path block: one answer per query.
// Uses the field widths of lcsp_pkg.
interface lcsp_out_if
  import lcsp_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [PATH_BITS-1:0] path_length;
  logic                 reachable;
  logic                 saturated;

  modport source (output valid, path_length, reachable, saturated, input ready);
  modport sink   (input valid, path_length, reachable, saturated, output ready);
endinterface

/* rtl/label_constrained_shortest_path.sv */
// Top level of the label-constrained shortest path engine.
// Depends on lcsp_pkg, lcsp_in_if, lcsp_out_if and lcsp_ram.
//
//   Channel  Direction  Carries
//   in_i     sink       op, node_a, node_b, word_length, label_letter
//   out_o    source     path_length, reachable, saturated (queries only)
//
// Clears and edge loads are taken back to back.
// A query with both nodes in range first sweeps the state memory, then seeds the start
// state. Each settled state costs a min-scan over all MAX_NODES*27 states, a settle step
// and a relax pass over every stored edge; one last empty min-scan ends the search and an
// answer scan over the 27 label states of the target node follows.
// Input is held off during a query.
// Reset clears the edge count and the controller; the result register is a skid stage,
// so the next item is taken while a result waits for its transfer.
module label_constrained_shortest_path
  import lcsp_pkg::*;
#(
  parameter int unsigned MAX_NODES = 64,
  parameter int unsigned MAX_EDGES = 256,
  parameter int unsigned COST_BITS = 19
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcsp_in_if.sink    in_i,
  lcsp_out_if.source out_o
);

  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned SC  = MAX_NODES * LABEL_STATES;
  localparam int unsigned SAW = $clog2(SC);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ETW = $clog2(MAX_EDGES + 1);
  localparam int unsigned EW  = 2 * NW + LEN_BITS + LABEL_BITS;
  localparam int unsigned SW  = 2 + COST_BITS;

  state_e                state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic [ETW-1:0]        edge_total_q, edge_total_d;
  logic                  any_q, any_d;
  logic                  fin_q, fin_d;
  logic                  pipe_v_q, pipe_v_d;
  logic                  side_q, side_d;
  logic                  ovf_q, ovf_d;

  logic [SAW-1:0]        scan_idx_q, scan_idx_d;
  logic [NW-1:0]         scan_node_q, scan_node_d;
  logic [LABEL_BITS-1:0] scan_lab_q, scan_lab_d;
  logic [SAW-1:0]        pipe_idx_q, pipe_idx_d;
  logic [NW-1:0]         pipe_node_q, pipe_node_d;
  logic [LABEL_BITS-1:0] pipe_lab_q, pipe_lab_d;
  logic [COST_BITS-1:0]  best_q, best_d;
  logic [SAW-1:0]        pick_idx_q, pick_idx_d;
  logic [NW-1:0]         pick_node_q, pick_node_d;
  logic [LABEL_BITS-1:0] pick_lab_q, pick_lab_d;
  logic [ETW-1:0]        e_idx_q, e_idx_d;
  logic [NW-1:0]         src_q, src_d;
  logic [NW-1:0]         dst_q, dst_d;
  logic [SAW-1:0]        tgt_idx_q, tgt_idx_d;
  logic [COST_BITS-1:0]  sum_q, sum_d;
  logic [PATH_BITS-1:0]  path_q, path_d;
  logic                  reach_q, reach_d;
  logic                  sat_q, sat_d;

  // Memory ports.
  logic                  e_we;
  logic [EW-1:0]         e_wdata, e_rdata;
  logic                  s_we;
  logic [SAW-1:0]        s_waddr, s_raddr;
  logic [SW-1:0]         s_wdata, s_rdata;

  // Fields of the read state entry and the read edge.
  logic                  st_reached, st_settled;
  logic [COST_BITS-1:0]  st_cost;
  logic [NW-1:0]         ed_a, ed_b, from_node, to_node;
  logic [LEN_BITS-1:0]   ed_len;
  logic [LABEL_BITS-1:0] ed_lab;
  logic [COST_BITS:0]    raw_sum;
  logic                  take, in_fire, out_fire, nodes_ok, scan_last;

  assign {st_reached, st_settled, st_cost} = s_rdata;
  assign {ed_a, ed_b, ed_len, ed_lab}      = e_rdata;
  assign from_node = side_q ? ed_b : ed_a;
  assign to_node   = side_q ? ed_a : ed_b;
  assign raw_sum   = {1'b0, best_q} + (COST_BITS + 1)'(ed_len);

  assign in_i.ready        = (state_q == ST_IDLE);
  assign in_fire           = in_i.valid && in_i.ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.path_length = path_q;
  assign out_o.reachable   = reach_q;
  assign out_o.saturated   = sat_q;
  assign out_fire          = out_valid_q && out_o.ready;

  assign nodes_ok = (32'(in_i.node_a) < 32'(MAX_NODES)) &&
                    (32'(in_i.node_b) < 32'(MAX_NODES));
  assign e_wdata  = {NW'(in_i.node_a), NW'(in_i.node_b), in_i.word_length, in_i.label_letter};

  // A reached entry becomes the running minimum when unsettled (or in the answer scan) and strictly cheaper.
  assign take = pipe_v_q && st_reached && (fin_q || !st_settled) &&
                (!any_q || st_cost < best_q);
  assign scan_last = fin_q ? (scan_lab_q == START_LABEL) : (scan_idx_q == SAW'(SC - 1));

  lcsp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (edge_total_q[EAW-1:0]),
    .wdata_i (e_wdata),
    .raddr_i (e_idx_q[EAW-1:0]),
    .rdata_o (e_rdata)
  );

  lcsp_ram #(.WIDTH(SW), .DEPTH(SC)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // Next state, counters and memory control.
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_fire;
    edge_total_d = edge_total_q;
    any_d        = any_q;
    fin_d        = fin_q;
    pipe_v_d     = 1'b0;
    side_d       = side_q;
    ovf_d        = ovf_q;
    scan_idx_d   = scan_idx_q;
    scan_node_d  = scan_node_q;
    scan_lab_d   = scan_lab_q;
    pipe_idx_d   = pipe_idx_q;
    pipe_node_d  = pipe_node_q;
    pipe_lab_d   = pipe_lab_q;
    best_d       = best_q;
    pick_idx_d   = pick_idx_q;
    pick_node_d  = pick_node_q;
    pick_lab_d   = pick_lab_q;
    e_idx_d      = e_idx_q;
    src_d        = src_q;
    dst_d        = dst_q;
    tgt_idx_d    = tgt_idx_q;
    sum_d        = sum_q;
    path_d       = path_q;
    reach_d      = reach_q;
    sat_d        = sat_q;
    e_we         = 1'b0;
    s_we         = 1'b0;
    s_waddr      = scan_idx_q;
    s_wdata      = '0;
    s_raddr      = scan_idx_q;

    // Running minimum over the scanned entries.
    if (take) begin
      any_d       = 1'b1;
      best_d      = st_cost;
      pick_idx_d  = pipe_idx_q;
      pick_node_d = pipe_node_q;
      pick_lab_d  = pipe_lab_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_i.op)
            OP_CLEAR: begin
              edge_total_d = '0;
              ovf_d        = 1'b0;
            end
            OP_ADD: begin
              if (edge_total_q < ETW'(MAX_EDGES) && in_i.label_letter < START_LABEL &&
                  nodes_ok) begin
                e_we         = 1'b1;
                edge_total_d = edge_total_q + 1'b1;
              end
            end
            OP_QUERY: begin
              src_d      = NW'(in_i.node_a);
              dst_d      = NW'(in_i.node_b);
              ovf_d      = 1'b0;
              any_d      = 1'b0;
              scan_idx_d = '0;
              state_d    = nodes_ok ? ST_CLEAR : ST_DONE;
            end
            default: ;
          endcase
        end
      end

      // Sweep the state memory to unreached, unsettled.
      ST_CLEAR: begin
        s_we       = 1'b1;
        s_waddr    = scan_idx_q;
        scan_idx_d = scan_idx_q + 1'b1;
        if (scan_idx_q == SAW'(SC - 1)) begin
          state_d = ST_INIT;
        end
      end

      // Seed the start state at cost zero, then open the first scan.
      ST_INIT: begin
        s_we        = 1'b1;
        s_waddr     = SAW'(src_q) * SAW'(LABEL_STATES) + SAW'(START_LABEL);
        s_wdata     = {1'b1, 1'b0, COST_BITS'(0)};
        scan_idx_d  = '0;
        scan_node_d = '0;
        scan_lab_d  = '0;
        any_d       = 1'b0;
        fin_d       = 1'b0;
        state_d     = ST_SCAN;
      end

      // Issue one read per cycle; the data is judged in the cycle after.
      ST_SCAN: begin
        s_raddr     = scan_idx_q;
        pipe_v_d    = 1'b1;
        pipe_idx_d  = scan_idx_q;
        pipe_node_d = scan_node_q;
        pipe_lab_d  = scan_lab_q;
        scan_idx_d  = scan_idx_q + 1'b1;
        if (scan_lab_q == START_LABEL) begin
          scan_lab_d  = '0;
          scan_node_d = scan_node_q + 1'b1;
        end else begin
          scan_lab_d = scan_lab_q + 1'b1;
        end
        if (scan_last) begin
          state_d = ST_SCAN_TAIL;
        end
      end

      // Last read is in; pick the next state, start the answer scan or finish.
      ST_SCAN_TAIL: begin
        if (fin_q) begin
          state_d = ST_DONE;
        end else if (any_d) begin
          state_d = ST_SETTLE;
        end else begin
          scan_idx_d  = SAW'(dst_q) * SAW'(LABEL_STATES);
          scan_node_d = dst_q;
          scan_lab_d  = '0;
          any_d       = 1'b0;
          fin_d       = 1'b1;
          state_d     = ST_SCAN;
        end
      end

      // Mark the chosen state settled and start the edge pass, or the next scan when no edges are stored.
      ST_SETTLE: begin
        s_we    = 1'b1;
        s_waddr = pick_idx_q;
        s_wdata = {1'b1, 1'b1, best_q};
        e_idx_d = '0;
        side_d  = 1'b0;
        if (edge_total_q == '0) begin
          scan_idx_d  = '0;
          scan_node_d = '0;
          scan_lab_d  = '0;
          any_d       = 1'b0;
          state_d     = ST_SCAN;
        end else begin
          state_d = ST_EDGE_RD;
        end
      end

      ST_EDGE_RD: begin
        state_d = ST_EDGE_CHK;
      end

      // Check one side of the edge and fetch the target state if it applies.
      ST_EDGE_CHK: begin
        if (ed_lab != pick_lab_q && from_node == pick_node_q) begin
          tgt_idx_d = SAW'(to_node) * SAW'(LABEL_STATES) + SAW'(ed_lab);
          s_raddr   = tgt_idx_d;
          if (raw_sum[COST_BITS]) begin
            sum_d = '1;
            ovf_d = 1'b1;
          end else begin
            sum_d = raw_sum[COST_BITS-1:0];
          end
          state_d = ST_RELAX;
        end else if (!side_q) begin
          side_d = 1'b1;
        end else begin
          side_d = 1'b0;
          if (e_idx_q + 1'b1 == edge_total_q) begin
            scan_idx_d  = '0;
            scan_node_d = '0;
            scan_lab_d  = '0;
            any_d       = 1'b0;
            state_d     = ST_SCAN;
          end else begin
            e_idx_d = e_idx_q + 1'b1;
            state_d = ST_EDGE_RD;
          end
        end
      end

      // Lower the target cost, then move to the other side, the next edge or, after the last edge, the next scan.
      ST_RELAX: begin
        if (!st_reached || sum_q < st_cost) begin
          s_we    = 1'b1;
          s_waddr = tgt_idx_q;
          s_wdata = {1'b1, st_settled, sum_q};
        end
        if (!side_q) begin
          side_d  = 1'b1;
          state_d = ST_EDGE_CHK;
        end else begin
          side_d = 1'b0;
          if (e_idx_q + 1'b1 == edge_total_q) begin
            scan_idx_d  = '0;
            scan_node_d = '0;
            scan_lab_d  = '0;
            any_d       = 1'b0;
            state_d     = ST_SCAN;
          end else begin
            e_idx_d = e_idx_q + 1'b1;
            state_d = ST_EDGE_RD;
          end
        end
      end

      // Load the result register once it is free.
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          path_d      = any_q ? PATH_BITS'(best_q) : '0;
          reach_d     = any_q;
          sat_d       = ovf_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      edge_total_q <= '0;
      any_q        <= 1'b0;
      fin_q        <= 1'b0;
      pipe_v_q     <= 1'b0;
      side_q       <= 1'b0;
      ovf_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      edge_total_q <= edge_total_d;
      any_q        <= any_d;
      fin_q        <= fin_d;
      pipe_v_q     <= pipe_v_d;
      side_q       <= side_d;
      ovf_q        <= ovf_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    scan_idx_q  <= scan_idx_d;
    scan_node_q <= scan_node_d;
    scan_lab_q  <= scan_lab_d;
    pipe_idx_q  <= pipe_idx_d;
    pipe_node_q <= pipe_node_d;
    pipe_lab_q  <= pipe_lab_d;
    best_q      <= best_d;
    pick_idx_q  <= pick_idx_d;
    pick_node_q <= pick_node_d;
    pick_lab_q  <= pick_lab_d;
    e_idx_q     <= e_idx_d;
    src_q       <= src_d;
    dst_q       <= dst_d;
    tgt_idx_q   <= tgt_idx_d;
    sum_q       <= sum_d;
    path_q      <= path_d;
    reach_q     <= reach_d;
    sat_q       <= sat_d;
  end

endmodule

/* rtl/lcsp_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module lcsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Testbench for label_constrained_shortest_path: directed and random graphs, with queries.
// Depends on lcsp_pkg, lcsp_in_if, lcsp_out_if and the RTL of the block.
module testbench;
  import lcsp_pkg::*;

  localparam int unsigned NODE_COUNT = 64;
  localparam int unsigned EDGE_SLOTS = 256;
  localparam int unsigned STATE_TOTAL = NODE_COUNT * LABEL_STATES;
  localparam longint unsigned COST_CAP = (64'd1 << PATH_BITS) - 1;
  localparam int unsigned STALL_LIMIT = 1500000;
  localparam op_e OP_UNUSED = op_e'(2'd3);

  typedef struct packed {
    logic [PATH_BITS-1:0] path_length;
    logic                 reachable;
    logic                 saturated;
  } answer_t;

  logic clk;
  logic rst_n;

  lcsp_in_if  in_bus ();
  lcsp_out_if out_bus ();

  label_constrained_shortest_path uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Clock generation.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Copy of the graph held by the testbench.
  logic [NODE_BITS-1:0]  graph_a [EDGE_SLOTS];
  logic [NODE_BITS-1:0]  graph_b [EDGE_SLOTS];
  logic [LEN_BITS-1:0]   graph_len [EDGE_SLOTS];
  logic [LABEL_BITS-1:0] graph_label [EDGE_SLOTS];
  int unsigned graph_edges;

  // Per-state search data for the predictor.
  longint unsigned state_cost [STATE_TOTAL];
  bit              state_reached [STATE_TOTAL];
  bit              state_settled [STATE_TOTAL];

  answer_t expected_answers[$];
  int unsigned mismatch_count;
  int unsigned stall_cycles;
  bit          sender_idles;
  bit          receiver_stalls;

  // Shortest path over (node, last label) states with the repeated-label rule.
  function automatic answer_t predict_path(logic [NODE_BITS-1:0] src,
                                           logic [NODE_BITS-1:0] dst);
    answer_t ans;
    bit clipped;
    bit any;
    int unsigned pick;
    int unsigned node;
    int unsigned lab;
    int unsigned from_n;
    int unsigned to_n;
    int unsigned idx;
    longint unsigned sum;
    longint unsigned best;
    ans = '0;
    clipped = 1'b0;
    for (int i = 0; i < STATE_TOTAL; i++) begin
      state_reached[i] = 1'b0;
      state_settled[i] = 1'b0;
      state_cost[i] = 0;
    end
    state_reached[src * LABEL_STATES + START_LABEL] = 1'b1;
    forever begin
      any = 1'b0;
      pick = 0;
      for (int i = 0; i < STATE_TOTAL; i++) begin
        if (state_reached[i] && !state_settled[i] &&
            (!any || state_cost[i] < state_cost[pick])) begin
          pick = i;
          any = 1'b1;
        end
      end
      if (!any) break;
      state_settled[pick] = 1'b1;
      node = pick / LABEL_STATES;
      lab = pick % LABEL_STATES;
      for (int e = 0; e < graph_edges; e++) begin
        if (graph_label[e] == lab) continue;
        for (int side = 0; side < 2; side++) begin
          from_n = side ? graph_b[e] : graph_a[e];
          to_n = side ? graph_a[e] : graph_b[e];
          if (from_n != node) continue;
          sum = state_cost[pick] + graph_len[e];
          if (sum > COST_CAP) begin
            sum = COST_CAP;
            clipped = 1'b1;
          end
          idx = to_n * LABEL_STATES + graph_label[e];
          if (!state_reached[idx] || sum < state_cost[idx]) begin
            state_reached[idx] = 1'b1;
            state_cost[idx] = sum;
          end
        end
      end
    end
    best = 0;
    for (int i = 0; i < LABEL_STATES; i++) begin
      idx = dst * LABEL_STATES + i;
      if (state_reached[idx] && (!ans.reachable || state_cost[idx] < best)) begin
        best = state_cost[idx];
        ans.reachable = 1'b1;
      end
    end
    ans.path_length = best[PATH_BITS-1:0];
    ans.saturated = clipped;
    return ans;
  endfunction

  // Updates the graph copy for one accepted item and queues any answer.
  function automatic void track_item(op_e op, logic [NODE_BITS-1:0] na, logic [NODE_BITS-1:0] nb,
                                     logic [LEN_BITS-1:0] len, logic [LABEL_BITS-1:0] lab);
    case (op)
      OP_CLEAR: begin
        graph_edges = 0;
      end
      OP_ADD: begin
        if (graph_edges < EDGE_SLOTS && lab < START_LABEL) begin
          graph_a[graph_edges] = na;
          graph_b[graph_edges] = nb;
          graph_len[graph_edges] = len;
          graph_label[graph_edges] = lab;
          graph_edges++;
        end
      end
      OP_QUERY: begin
        expected_answers.push_back(predict_path(na, nb));
      end
      default: begin
      end
    endcase
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Drives one item and holds it until the transfer happens.
  task automatic send_item(op_e op, logic [NODE_BITS-1:0] na, logic [NODE_BITS-1:0] nb,
                           logic [LEN_BITS-1:0] len, logic [LABEL_BITS-1:0] lab);
    int unsigned gap;
    @(negedge clk);
    in_bus.valid = 1'b1;
    in_bus.op = op;
    in_bus.node_a = na;
    in_bus.node_b = nb;
    in_bus.word_length = len;
    in_bus.label_letter = lab;
    do @(posedge clk); while (!in_bus.ready);
    track_item(op, na, nb, len, lab);
    gap = sender_idles ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Withdraws the input and waits until every expected answer has arrived.
  task automatic wait_for_answers();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  // Receiver readiness changes at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready = 1'b0;
    end else if (!receiver_stalls) begin
      out_bus.ready = 1'b1;
    end else begin
      out_bus.ready = ($urandom_range(99) < 65);
    end
  end

  // Answer check and watchdog at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_answers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected answer: length=%0d reachable=%0b saturated=%0b",
                     out_bus.path_length, out_bus.reachable, out_bus.saturated);
        end else begin
          answer_t want;
          want = expected_answers.pop_front();
          if (out_bus.path_length !== want.path_length ||
              out_bus.reachable !== want.reachable ||
              out_bus.saturated !== want.saturated) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"Answer mismatch: expected length=%0d reachable=%0b saturated=%0b,",
                        " got length=%0d reachable=%0b saturated=%0b"},
                       want.path_length, want.reachable, want.saturated,
                       out_bus.path_length, out_bus.reachable, out_bus.saturated);
          end
        end
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("label_constrained_shortest_path test failed");
          $finish;
        end
      end
    end
  end

  // Extremes of the fields, every operation and the special cases.
  task automatic test_directed();
    send_item(OP_CLEAR, 6'd0, 6'd0, 8'd0, 5'd0);
    send_item(OP_QUERY, 6'd0, 6'd63, 8'd0, 5'd0);     // empty graph
    send_item(OP_ADD, 6'd0, 6'd63, 8'd255, 5'd0);
    send_item(OP_ADD, 6'd63, 6'd21, 8'd0, 5'd25);     // zero length
    send_item(OP_ADD, 6'd21, 6'd21, 8'd7, 5'd3);      // self loop
    send_item(OP_ADD, 6'd42, 6'd21, 8'd9, 5'd26);     // bad label, dropped
    send_item(OP_ADD, 6'd42, 6'd21, 8'd9, 5'd31);     // bad label, dropped
    send_item(OP_UNUSED, 6'd42, 6'd21, 8'd9, 5'd1);   // ignored op
    send_item(OP_QUERY, 6'd0, 6'd21, 8'd0, 5'd0);
    send_item(OP_QUERY, 6'd63, 6'd63, 8'd255, 5'd31); // same endpoints
    send_item(OP_QUERY, 6'd0, 6'd42, 8'd0, 5'd0);     // unreachable
    // Consecutive edges with the same label are blocked; a detour exists.
    send_item(OP_CLEAR, 6'd63, 6'd63, 8'd255, 5'd31);
    send_item(OP_ADD, 6'd1, 6'd2, 8'd1, 5'd4);
    send_item(OP_ADD, 6'd2, 6'd3, 8'd1, 5'd4);
    send_item(OP_QUERY, 6'd1, 6'd3, 8'd0, 5'd0);
    send_item(OP_ADD, 6'd2, 6'd4, 8'd10, 5'd5);
    send_item(OP_ADD, 6'd4, 6'd2, 8'd20, 5'd6);
    send_item(OP_QUERY, 6'd1, 6'd3, 8'd0, 5'd0);
    send_item(OP_QUERY, 6'd3, 6'd1, 8'd0, 5'd0);
  endtask

  // Fills the edge store past its end; extra edges must be ignored.
  task automatic test_store_full();
    send_item(OP_CLEAR, 6'd0, 6'd0, 8'd0, 5'd0);
    for (int i = 0; i < EDGE_SLOTS; i++)
      send_item(OP_ADD, 6'(10 + (i % 2)), 6'(11 - (i % 2)), 8'($urandom_range(255, 1)),
                (i % 3 == 0) ? 5'd7 : 5'd8);
    send_item(OP_ADD, 6'd11, 6'd12, 8'd1, 5'd2);
    send_item(OP_QUERY, 6'd10, 6'd11, 8'd0, 5'd0);
    send_item(OP_QUERY, 6'd10, 6'd12, 8'd0, 5'd0);
  endtask

  // The sender holds off until every answer is in.
  task automatic test_drain_pause();
    send_item(OP_QUERY, 6'd1, 6'd4, 8'd0, 5'd0);
    wait_for_answers();
    send_item(OP_QUERY, 6'd4, 6'd1, 8'd0, 5'd0);
  endtask

  // Small random graphs with queries among their nodes, plus some noise.
  task automatic test_random(int unsigned item_goal);
    logic [NODE_BITS-1:0]  nodes [4];
    logic [LABEL_BITS-1:0] labels [3];
    int unsigned sent;
    int unsigned edge_goal;
    sent = 0;
    while (sent < item_goal) begin
      sender_idles = ($urandom_range(9) != 0);
      receiver_stalls = ($urandom_range(9) != 0);
      foreach (nodes[i]) nodes[i] = 6'($urandom_range(63));
      foreach (labels[i]) labels[i] = 5'($urandom_range(25));
      send_item(OP_CLEAR, 6'($urandom_range(63)), 6'($urandom_range(63)),
                8'($urandom_range(255)), 5'($urandom_range(31)));
      edge_goal = $urandom_range(9, 2);
      for (int i = 0; i < edge_goal; i++)
        send_item(OP_ADD, nodes[$urandom_range(3)], nodes[$urandom_range(3)],
                  ($urandom_range(15) == 0) ? 8'd0 : 8'($urandom_range(255, 1)),
                  labels[$urandom_range(2)]);
      if ($urandom_range(3) == 0)
        send_item(OP_ADD, nodes[0], nodes[1], 8'($urandom_range(255)),
                  5'($urandom_range(31, 26)));
      if ($urandom_range(5) == 0)
        send_item(OP_UNUSED, 6'($urandom_range(63)), 6'($urandom_range(63)),
                  8'($urandom_range(255)), 5'($urandom_range(31)));
      send_item(OP_QUERY, nodes[$urandom_range(3)],
                ($urandom_range(7) == 0) ? 6'($urandom_range(63)) : nodes[$urandom_range(3)],
                8'($urandom_range(255)), 5'($urandom_range(31)));
      sent += edge_goal + 2;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.op = OP_CLEAR;
    in_bus.node_a = '0;
    in_bus.node_b = '0;
    in_bus.word_length = '0;
    in_bus.label_letter = '0;
    out_bus.ready = 1'b0;
    graph_edges = 0;
    mismatch_count = 0;
    stall_cycles = 0;
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_drain_pause();
    test_store_full();
    test_random(120);

    // Drain, then let the block settle.
    wait_for_answers();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("label_constrained_shortest_path test passed");
    end else begin
      $display("label_constrained_shortest_path test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lcsp_pkg.sv
rtl/lcsp_in_if.sv
rtl/lcsp_out_if.sv
rtl/lcsp_ram.sv
rtl/label_constrained_shortest_path.sv
tb/sv/testbench.sv
